FILE: src/lcs_pkg.sv
// Shared constants, types and helpers for the Life stencil stream unit.
package lcs_pkg;

	localparam int MAX_COLS   = 128;
	localparam int MAX_ROWS   = 128;
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int SIZE_W     = 8;
	localparam int MIN_SIZE   = 3;
	localparam int GRID_RESET = 25;
	localparam int WIN_CELLS  = 3;
	localparam int CNT_W      = 4;

	// Rule B3/S23 neighbor counts.
	localparam logic [CNT_W-1:0] NBR_BIRTH   = CNT_W'(3);
	localparam logic [CNT_W-1:0] NBR_SURVIVE = CNT_W'(2);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = CFG_IDX_W'(1);

	// Request from the position logic to the line store.
	typedef struct packed {
		logic             rd_en;
		logic [COL_W-1:0] rd_addr;
		logic             wr_en;
		logic [COL_W-1:0] wr_addr;
		logic             wr_top;
		logic             wr_mid;
	} ls_req_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] hi);
		logic [SIZE_W-1:0] r;
		if (v < SIZE_W'(MIN_SIZE)) begin
			r = SIZE_W'(MIN_SIZE);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

FILE: src/life_cell_stencil_stream_unit.sv
// Top level of the Life B3/S23 stencil stream unit.
//
//  channel  | direction | contents
//  s_*      | in        | tdata[0] cell_alive, tuser[0] frame_start
//  m_*      | out       | tdata[6:0] out_row, [13:7] out_col, [14] next_alive; tlast frame_last
//  cfg_*    | in        | index 0 grid_rows, index 1 grid_cols, 8-bit data
//
// One cell is taken per clock while s_tready is high; a result passes stage 1, stage 2 and the
// output register after its cell is accepted. The line store read is registered, so each cell
// passes the read register and then the window before the count is registered at the output.
// Reset clears the line store valid bits at once; no clearing pass is needed.
// An output register plus a skid stage absorb a stall; s_tready drops only while the skid
// stage is full.
module life_cell_stencil_stream_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // [0] cell_alive
	input  logic [0:0]                       s_tuser,  // [0] frame_start
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata,  // [6:0] out_row, [13:7] out_col, [14] next_alive
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [lcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lcs_pkg::SIZE_W-1:0]       cfg_wdata
);
	import lcs_pkg::*;

	logic [SIZE_W-1:0] rows_q, cols_q, rows_c, cols_c;
	logic [ROW_W-1:0]  row_q, r0;
	logic [COL_W-1:0]  col_q, c0;
	logic [SIZE_W-1:0] r0x, c0x, r_inc, c_inc;
	logic              adv, accept, emit0, last0;

	logic              valid_s1, cur_s1, emit_s1, last_s1;
	logic [ROW_W-1:0]  orow_s1;
	logic [COL_W-1:0]  ocol_s1, c_s1;

	logic              valid_s2, last_s2;
	logic [ROW_W-1:0]  orow_s2;
	logic [COL_W-1:0]  ocol_s2;

	ls_req_t           ls_req;
	logic              ls_top, ls_mid;

	logic [2:0]        win_in  [WIN_CELLS];
	logic [2:0]        win_col [WIN_CELLS];
	logic [1:0]        win_cnt [WIN_CELLS];
	logic              center, next_c;
	logic [CNT_W-1:0]  sum9, nbr;

	logic              out_valid_q, skid_valid_q, out_take, new_res;
	logic [14:0]       out_data_q, skid_data_q, res_data;
	logic              out_last_q, skid_last_q;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= SIZE_W'(GRID_RESET);
			cols_q <= SIZE_W'(GRID_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_ROWS: rows_q <= cfg_wdata;
				CFG_GRID_COLS: cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign rows_c = clamp_size(rows_q, SIZE_W'(MAX_ROWS));
	assign cols_c = clamp_size(cols_q, SIZE_W'(MAX_COLS));

	// Position of the incoming cell
	assign adv      = !skid_valid_q;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	assign r0    = s_tuser[0] ? '0 : row_q;
	assign c0    = s_tuser[0] ? '0 : col_q;
	assign r0x   = SIZE_W'(r0);
	assign c0x   = SIZE_W'(c0);
	assign r_inc = r0x + SIZE_W'(1);
	assign c_inc = c0x + SIZE_W'(1);
	assign emit0 = (r0x >= SIZE_W'(2)) && (c0x >= SIZE_W'(2)) && (r0x < rows_c) && (c0x < cols_c);
	assign last0 = (r_inc == rows_c) && (c_inc == cols_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (c_inc >= cols_c) begin
				col_q <= '0;
				row_q <= (r_inc >= rows_c) ? '0 : ROW_W'(r_inc);
			end else begin
				col_q <= COL_W'(c_inc);
				row_q <= r0;
			end
		end
	end

	// Stage 1: line store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1  <= s_tdata[0];
			emit_s1 <= emit0;
			last_s1 <= last0;
			orow_s1 <= r0 - ROW_W'(1);
			ocol_s1 <= c0 - COL_W'(1);
			c_s1    <= c0;
		end
	end

	// The cell leaving stage 1 rotates its column: the row above moves up a slot.
	always_comb begin
		ls_req.rd_en   = accept;
		ls_req.rd_addr = c0;
		ls_req.wr_en   = adv && valid_s1;
		ls_req.wr_addr = c_s1;
		ls_req.wr_top  = ls_mid;
		ls_req.wr_mid  = cur_s1;
	end

	lcs_line_store u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ls_req),
		.rd_top (ls_top),
		.rd_mid (ls_mid)
	);

	// Window: a chain of column cells, the newest column at the highest index.
	for (genvar i = 0; i < WIN_CELLS; i++) begin : g_win
		if (i == WIN_CELLS - 1) begin : g_head
			assign win_in[i] = {cur_s1, ls_mid, ls_top};
		end else begin : g_body
			assign win_in[i] = win_col[i+1];
		end
		lcs_win_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (adv && valid_s1),
			.col_in   (win_in[i]),
			.col_q    (win_col[i]),
			.live_cnt (win_cnt[i])
		);
	end

	// Stage 2: window holds the neighborhood of the reported cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			last_s2 <= last_s1;
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
		end
	end

	assign center = win_col[1][1];
	assign sum9   = CNT_W'(win_cnt[0]) + CNT_W'(win_cnt[1]) + CNT_W'(win_cnt[2]);
	assign nbr    = sum9 - CNT_W'(center);
	assign next_c = (nbr == NBR_BIRTH) || (center && (nbr == NBR_SURVIVE));

	assign res_data = {next_c, ocol_s2, orow_s2};
	assign new_res  = adv && valid_s2;
	assign out_take = out_valid_q && m_tready;

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (new_res) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_data_q <= skid_data_q;
				out_last_q <= skid_last_q;
			end
		end else if (new_res) begin
			if (!out_valid_q || out_take) begin
				out_data_q <= res_data;
				out_last_q <= last_s2;
			end else begin
				skid_data_q <= res_data;
				skid_last_q <= last_s2;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_data_q};
	assign m_tlast  = out_last_q;

	// The skid stage only ever holds a transaction behind a full output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage full while output register empty");

	// The skid stage fills only when the output was stalled.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready))
		else $error("skid stage filled without an output stall");

	// Reported cells are interior, never on row or column zero.
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[6:0] != 7'd0) && (out_data_q[13:7] != 7'd0))
		else $error("border cell reported");

endmodule

FILE: src/lcs_line_store.sv
// Two-row line store: one memory entry per column holding the rows above the incoming cell.
module lcs_line_store (
	input  logic             clk,
	input  logic             arst_n,
	input  lcs_pkg::ls_req_t req,
	output logic             rd_top,
	output logic             rd_mid
);
	import lcs_pkg::*;

	// Entry bit 0 is the row two above, bit 1 the row directly above.
	logic [1:0]          mem [MAX_COLS];
	logic [MAX_COLS-1:0] valid_q;
	logic [1:0]          mem_rd_q;
	logic                vld_rd_q;
	logic                fwd_q;
	logic [1:0]          fwd_data_q;
	logic                hit;

	assign hit = req.rd_en && req.wr_en && (req.rd_addr == req.wr_addr);

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= {req.wr_mid, req.wr_top};
		end
		if (req.rd_en) begin
			mem_rd_q   <= mem[req.rd_addr];
			fwd_data_q <= {req.wr_mid, req.wr_top};
		end
	end

	// Entries never written read as zero, as after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_rd_q <= valid_q[req.rd_addr];
				fwd_q    <= hit;
			end
		end
	end

	always_comb begin
		if (fwd_q) begin
			{rd_mid, rd_top} = fwd_data_q;
		end else if (vld_rd_q) begin
			{rd_mid, rd_top} = mem_rd_q;
		end else begin
			{rd_mid, rd_top} = 2'b00;
		end
	end

endmodule

FILE: src/lcs_win_cell.sv
// One column of the 3x3 window: holds three bits and passes them to its left neighbor.
module lcs_win_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic [2:0] col_in,
	output logic [2:0] col_q,
	output logic [1:0] live_cnt
);
	import lcs_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= col_in;
		end
	end

	assign live_cnt = 2'(col_q[0]) + 2'(col_q[1]) + 2'(col_q[2]);

endmodule

FILE: test/tb_life_cell_stencil_stream_unit.sv
// Self-checking testbench for the Life B3/S23 stencil stream unit.
module tb_life_cell_stencil_stream_unit;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS = 1950;

	typedef struct packed {
		logic [6:0] row;
		logic [6:0] col;
		logic       alive;
		logic       last;
	} next_cell_t;

	// Tracks one generation of the grid and holds the next-state reports still owed.
	class next_gen_board;
		bit         top_line[lcs_pkg::MAX_COLS];
		bit         mid_line[lcs_pkg::MAX_COLS];
		bit [8:0]   win;
		int         row_pos;
		int         col_pos;
		int         rows_reg;
		int         cols_reg;
		int         errors;
		next_cell_t pending_next[$];

		function new();
			for (int k = 0; k < lcs_pkg::MAX_COLS; k++) begin
				top_line[k] = 1'b0;
				mid_line[k] = 1'b0;
			end
			win      = '0;
			row_pos  = 0;
			col_pos  = 0;
			rows_reg = lcs_pkg::GRID_RESET;
			cols_reg = lcs_pkg::GRID_RESET;
			errors   = 0;
		endfunction

		function int bounded(int v, int hi);
			int r;
			if (v < lcs_pkg::MIN_SIZE) begin
				r = lcs_pkg::MIN_SIZE;
			end else if (v > hi) begin
				r = hi;
			end else begin
				r = v;
			end
			return r;
		endfunction

		function int eff_rows();
			return bounded(rows_reg, lcs_pkg::MAX_ROWS);
		endfunction

		function int eff_cols();
			return bounded(cols_reg, lcs_pkg::MAX_COLS);
		endfunction

		function int pending();
			return pending_next.size();
		endfunction

		function void write_reg(logic [lcs_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
			if (idx == lcs_pkg::CFG_GRID_ROWS) begin
				rows_reg = val;
			end else if (idx == lcs_pkg::CFG_GRID_COLS) begin
				cols_reg = val;
			end
		endfunction

		function void note_cell(bit alive_in, bit fs);
			int         rows;
			int         cols;
			int         r;
			int         c;
			int         cnt;
			bit         top_b;
			bit         mid_b;
			next_cell_t res;
			rows = eff_rows();
			cols = eff_cols();
			if (fs) begin
				row_pos = 0;
				col_pos = 0;
			end
			r     = row_pos;
			c     = col_pos;
			top_b = 1'b0;
			mid_b = 1'b0;
			if (c < lcs_pkg::MAX_COLS) begin
				top_b       = top_line[c];
				mid_b       = mid_line[c];
				top_line[c] = mid_b;
				mid_line[c] = alive_in;
			end
			win = {alive_in, mid_b, top_b, win[8:3]};
			if (r >= 2 && c >= 2 && r < rows && c < cols) begin
				cnt = 0;
				for (int k = 0; k < 9; k++) begin
					if (k != 4 && win[k]) cnt++;
				end
				res.row   = 7'(r - 1);
				res.col   = 7'(c - 1);
				res.alive = (cnt == lcs_pkg::NBR_BIRTH) ||
					(win[4] && cnt == lcs_pkg::NBR_SURVIVE);
				res.last  = (r == rows - 1) && (c == cols - 1);
				pending_next.push_back(res);
			end
			if (c + 1 >= cols) begin
				col_pos = 0;
				row_pos = (r + 1 >= rows) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		function void check_next(logic [15:0] data, logic last);
			next_cell_t res;
			if (pending_next.size() == 0) begin
				$display("%0t: unexpected result row %0d col %0d alive %0d last %0d",
					$time, data[6:0], data[13:7], data[14], last);
				errors++;
				return;
			end
			res = pending_next.pop_front();
			if (data[6:0] !== res.row) begin
				$display("%0t: out_row expected %0d actual %0d", $time, res.row, data[6:0]);
				errors++;
			end
			if (data[13:7] !== res.col) begin
				$display("%0t: out_col expected %0d actual %0d", $time, res.col, data[13:7]);
				errors++;
			end
			if (data[14] !== res.alive) begin
				$display("%0t: next_alive expected %0d actual %0d (row %0d col %0d)",
					$time, res.alive, data[14], res.row, res.col);
				errors++;
			end
			if (last !== res.last) begin
				$display("%0t: frame_last expected %0d actual %0d (row %0d col %0d)",
					$time, res.last, last, res.row, res.col);
				errors++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata = '0;   // [0] cell_alive
	logic [0:0]                    s_tuser = '0;   // [0] frame_start
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [15:0]                   m_tdata;        // [6:0] out_row, [13:7] out_col, [14] next_alive
	logic                          m_tlast;
	logic                          cfg_we = 1'b0;
	logic [lcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lcs_pkg::SIZE_W-1:0]    cfg_wdata = '0;

	next_gen_board sb = new();
	int            cycles = 0;
	int            items_sent = 0;
	int            burst_left = 0;
	int            ready_run = 0;
	int            stall_run = 0;

	life_cell_stencil_stream_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** life_cell_stencil_stream_unit: FAILED **");
			$finish;
		end
	end

	// Every transaction on the three ports is seen here at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_next(m_tdata, m_tlast);
			if (s_tvalid && s_tready) sb.note_cell(s_tdata[0], s_tuser[0]);
			if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
		end
	end

	// The receiver alternates long open stretches with short ready/stall runs.
	always @(negedge clk) begin
		if (ready_run > 0) begin
			m_tready = 1'b1;
			ready_run--;
		end else if (stall_run > 0) begin
			m_tready = 1'b0;
			stall_run--;
		end else begin
			m_tready = 1'b1;
			if ($urandom_range(0, 5) == 0) begin
				ready_run = $urandom_range(100, 300);
				stall_run = 0;
			end else begin
				ready_run = $urandom_range(0, 8);
				stall_run = $urandom_range(1, 6);
			end
		end
	end

	task automatic send_item(input bit alive_in, input bit fs);
		int gap;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {7'd0, alive_in};
		s_tuser  = fs;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(0, 24);
		end
	endtask

	// Lowers tvalid and holds off until no result is owed, plus a settling wait for cells
	// that are still in the pipeline without a report of their own.
	task automatic wait_results_done();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [lcs_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic send_pattern(input bit [8:0] pat);
		for (int k = 0; k < 9; k++) send_item(pat[k], k == 0);
	endtask

	task automatic send_grid(input int n_cells, input bit with_fs, input int density);
		for (int k = 0; k < n_cells; k++) begin
			send_item($urandom_range(0, 99) < density, with_fs && k == 0);
		end
	endtask

	task automatic send_noise(input int n);
		for (int k = 0; k < n; k++) begin
			send_item(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
		end
	endtask

	function automatic int pick_size();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0) return $urandom_range(0, 2);
		if (k == 1) return $urandom_range(129, 255);
		return $urandom_range(3, 10);
	endfunction

	function automatic int pick_density();
		int k;
		k = $urandom_range(0, 3);
		case (k)
			0: return 15;
			1: return 35;
			2: return 50;
			default: return 70;
		endcase
	endfunction

	initial begin
		int rows_v;
		int cols_v;
		int frames;
		int cells;
		int kind;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Smallest grid: crowded center dies, center with two neighbors survives,
		// dead center with three neighbors is born.
		write_reg(lcs_pkg::CFG_GRID_ROWS, 8'd3);
		write_reg(lcs_pkg::CFG_GRID_COLS, 8'd3);
		send_pattern(9'h1FF);
		send_pattern(9'h038);
		send_pattern(9'h0A1);
		wait_results_done();

		// Sizes below the minimum and above the maximum, widest and tallest grids.
		write_reg(lcs_pkg::CFG_GRID_ROWS, 8'h00);
		write_reg(lcs_pkg::CFG_GRID_COLS, 8'hFF);
		send_grid(sb.eff_rows() * sb.eff_cols(), 1'b1, 35);
		wait_results_done();
		write_reg(lcs_pkg::CFG_GRID_ROWS, 8'd200);
		write_reg(lcs_pkg::CFG_GRID_COLS, 8'd1);
		send_grid(sb.eff_rows() * sb.eff_cols(), 1'b1, 40);
		wait_results_done();

		while (items_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 3);
			if (kind != 3) begin
				rows_v = pick_size();
				cols_v = pick_size();
				// Keep one dimension small when the other is at its maximum.
				if (rows_v > 10) cols_v = $urandom_range(0, 3);
				if (cols_v > 10) rows_v = $urandom_range(0, 3);
				if (kind != 1) write_reg(lcs_pkg::CFG_GRID_ROWS, 8'(rows_v));
				if (kind != 2) write_reg(lcs_pkg::CFG_GRID_COLS, 8'(cols_v));
			end
			cells  = sb.eff_rows() * sb.eff_cols();
			frames = (cells > 150) ? 1 : $urandom_range(1, 4);
			for (int f = 0; f < frames; f++) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					send_grid(cells, 1'b1, pick_density());
				end else if (kind == 7) begin
					send_grid(cells, 1'b0, pick_density());
				end else if (kind == 8) begin
					send_grid($urandom_range(1, cells), 1'b1, pick_density());
				end else begin
					send_noise($urandom_range(1, 30));
				end
				if ($urandom_range(0, 5) == 0) wait_results_done();
			end
			wait_results_done();
		end

		wait_results_done();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("** life_cell_stencil_stream_unit: PASSED **");
		end else begin
			$display("** life_cell_stencil_stream_unit: FAILED **");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/lcs_pkg.sv
src/lcs_line_store.sv
src/lcs_win_cell.sv
src/life_cell_stencil_stream_unit.sv
test/tb_life_cell_stencil_stream_unit.sv
